[rtl/hrp_pkg.sv]
// ----------------------------------------------------------------------------
// hrp_pkg
// Types, codes and helper functions shared by the HTTP response header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrp_pkg;

    // Size of the key store; the effective key limit is capped one below it
    localparam int KEY_STORE_BYTES = 32;
    localparam int KEY_CAP         = KEY_STORE_BYTES - 1;

    // Status line prefix length ("HTTP/1")
    localparam int PREFIX_LEN = 6;

    // Configuration register indexes
    localparam logic CFG_KEY_LIMIT = 1'b0;
    localparam logic CFG_MSG_LIMIT = 1'b1;

    // Configuration reset values
    localparam logic [4:0]  KEY_LIMIT_RESET = 5'd31;
    localparam logic [16:0] MSG_LIMIT_RESET = 17'h10000;

    // Character codes
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;

    // Parser phases, one-hot
    typedef enum logic [9:0] {
        PH_PREFIX      = 10'b00_0000_0001,
        PH_SUBVER      = 10'b00_0000_0010,
        PH_CODE        = 10'b00_0000_0100,
        PH_TEXT        = 10'b00_0000_1000,
        PH_KEY         = 10'b00_0001_0000,
        PH_SPACES      = 10'b00_0010_0000,
        PH_VALUE_FIRST = 10'b00_0100_0000,
        PH_VALUE       = 10'b00_1000_0000,
        PH_LINE_LF     = 10'b01_0000_0000,
        PH_FINAL_LF    = 10'b10_0000_0000
    } t_phase;

    // Event codes of the result word
    typedef enum logic [3:0] {
        EV_NONE       = 4'd0,
        EV_CODE       = 4'd1,
        EV_KEY_BYTE   = 4'd2,
        EV_KEY_END    = 4'd3,
        EV_VALUE_BYTE = 4'd4,
        EV_HEADER     = 4'd5,
        EV_DONE       = 4'd6,
        EV_BAD        = 4'd7,
        EV_LONG       = 4'd8
    } t_event;

    // Parser state carried from byte to byte
    typedef struct packed {
        t_phase      phase;
        logic [16:0] msg_count;
        logic [15:0] field_count;
        logic        prefix_ok;
        logic [15:0] code_acc;
        logic [4:0]  saved_klen;
    } t_state;

    // One result word
    typedef struct packed {
        t_event      event_res;
        logic [7:0]  data_byte;
        logic [15:0] status_code;
        logic [4:0]  key_length;
        logic [15:0] value_length;
        logic [16:0] consumed_bytes;
    } t_result;

    localparam t_state STATE_RESTART = '{
        phase:       PH_PREFIX,
        msg_count:   17'd0,
        field_count: 16'd0,
        prefix_ok:   1'b1,
        code_acc:    16'd0,
        saved_klen:  5'd0
    };

    // Expected prefix character at a position below PREFIX_LEN
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_H;
            3'd1:    c = CH_T;
            3'd2:    c = CH_T;
            3'd3:    c = CH_P;
            3'd4:    c = CH_SLASH;
            3'd5:    c = CH_ONE;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic is_key_char(input logic [7:0] b);
        return (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z) ||
               (b >= CH_ZERO && b <= CH_NINE) || b == CH_DASH || b == CH_UNDER;
    endfunction

    // Saturating 16-bit increment
    function automatic logic [15:0] bump16(input logic [15:0] v);
        return (v != 16'hFFFF) ? v + 16'd1 : 16'hFFFF;
    endfunction

endpackage

`default_nettype wire

[rtl/hrp_in_if.sv]
// ----------------------------------------------------------------------------
// hrp_in_if
// Input byte channel: valid/ready handshake with one raw byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

[rtl/hrp_out_if.sv]
// ----------------------------------------------------------------------------
// hrp_out_if
// Result channel: valid/ready handshake with one parser event per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_res;
    logic [7:0]  data_byte;
    logic [15:0] status_code;
    logic [4:0]  key_length;
    logic [15:0] value_length;
    logic [16:0] consumed_bytes;

    modport source (output valid, output event_res, output data_byte,
                    output status_code, output key_length, output value_length,
                    output consumed_bytes, input ready);
    modport sink   (input valid, input event_res, input data_byte,
                    input status_code, input key_length, input value_length,
                    input consumed_bytes, output ready);
endinterface

`default_nettype wire

[rtl/hrp_step.sv]
// ----------------------------------------------------------------------------
// hrp_step
// Next-state and event logic for one byte: takes the current parser state and
// a byte, returns the following state and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module hrp_step (
    input  hrp_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    input  logic [4:0]       i_key_limit,
    input  logic [16:0]      i_msg_limit,
    output hrp_pkg::t_state  o_state,
    output hrp_pkg::t_result o_result
);
    import hrp_pkg::*;

    logic [17:0] pos;
    logic [8:0]  key_lim;
    logic [19:0] code_next;
    logic [15:0] code_sat;
    logic        finish;
    t_state      st;
    t_result     res;

    // Position of this byte in the message, and effective key limit
    assign pos     = {1'b0, i_state.msg_count} + 18'd1;
    assign key_lim = (9'(i_key_limit) > 9'(KEY_CAP)) ? 9'(KEY_CAP) : 9'(i_key_limit);

    // Decimal accumulate: acc * 10 + digit, saturating
    assign code_next = ({4'd0, i_state.code_acc} << 3) + ({4'd0, i_state.code_acc} << 1)
                       + 20'(i_byte - CH_ZERO);
    assign code_sat  = (code_next > 20'h0FFFF) ? 16'hFFFF : code_next[15:0];

    // Parse one byte
    always_comb begin
        st     = i_state;
        finish = 1'b0;
        res    = '{event_res: EV_NONE, data_byte: 8'd0, status_code: 16'd0,
                   key_length: 5'd0, value_length: 16'd0, consumed_bytes: 17'd0};

        if (pos > {1'b0, i_msg_limit}) begin
            res.event_res = EV_LONG;
            finish        = 1'b1;
        end else begin
            st.msg_count = pos[16:0];
            case (i_state.phase)
                PH_PREFIX: begin
                    if (i_byte == CH_DOT) begin
                        if (i_state.field_count != 16'(PREFIX_LEN) || !i_state.prefix_ok) begin
                            res.event_res = EV_BAD;
                            finish        = 1'b1;
                        end else begin
                            st.field_count = 16'd0;
                            st.phase       = PH_SUBVER;
                        end
                    end else if ((i_byte >= CH_UP_A && i_byte <= CH_UP_Z) ||
                                 i_byte == CH_SLASH || i_byte == CH_ONE) begin
                        if (i_state.field_count >= 16'(PREFIX_LEN) ||
                            prefix_char(i_state.field_count[2:0]) != i_byte) begin
                            st.prefix_ok = 1'b0;
                        end
                        st.field_count = bump16(i_state.field_count);
                    end else begin
                        res.event_res = EV_BAD;
                        finish        = 1'b1;
                    end
                end
                PH_SUBVER: begin
                    if (i_byte == CH_SPACE) begin
                        st.code_acc = 16'd0;
                        st.phase    = PH_CODE;
                    end else if ((i_byte == CH_ZERO || i_byte == CH_ONE) &&
                                 i_state.field_count == 16'd0) begin
                        st.field_count = 16'd1;
                    end else begin
                        res.event_res = EV_BAD;
                        finish        = 1'b1;
                    end
                end
                PH_CODE: begin
                    if (i_byte == CH_SPACE) begin
                        res.event_res = EV_CODE;
                        st.phase      = PH_TEXT;
                    end else if (i_byte >= CH_ZERO && i_byte <= CH_NINE) begin
                        st.code_acc = code_sat;
                    end else begin
                        res.event_res = EV_BAD;
                        finish        = 1'b1;
                    end
                end
                PH_TEXT: begin
                    if (i_byte == CH_LF) begin
                        st.field_count = 16'd0;
                        st.phase       = PH_KEY;
                    end else if (i_byte == CH_CR) begin
                        st.phase = PH_LINE_LF;
                    end
                end
                PH_KEY: begin
                    if (i_byte == CH_COLON) begin
                        st.saved_klen  = i_state.field_count[4:0];
                        res.event_res  = EV_KEY_END;
                        res.key_length = i_state.field_count[4:0];
                        st.phase       = PH_SPACES;
                    end else if (i_state.field_count == 16'd0 && i_byte == CH_LF) begin
                        res.event_res      = EV_DONE;
                        res.consumed_bytes = pos[16:0];
                        finish             = 1'b1;
                    end else if (i_state.field_count == 16'd0 && i_byte == CH_CR) begin
                        st.phase = PH_FINAL_LF;
                    end else if (i_state.field_count >= 16'(key_lim) ||
                                 !is_key_char(i_byte)) begin
                        res.event_res = EV_BAD;
                        finish        = 1'b1;
                    end else begin
                        res.event_res  = EV_KEY_BYTE;
                        res.data_byte  = i_byte;
                        st.field_count = bump16(i_state.field_count);
                    end
                end
                PH_SPACES: begin
                    // first non-space byte is taken as it is
                    if (i_byte != CH_SPACE) begin
                        res.event_res  = EV_VALUE_BYTE;
                        res.data_byte  = i_byte;
                        st.field_count = 16'd1;
                        st.phase       = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (i_byte >= CH_SPACE) begin
                        res.event_res  = EV_VALUE_BYTE;
                        res.data_byte  = i_byte;
                        st.field_count = bump16(i_state.field_count);
                    end else if (i_byte == CH_LF || i_byte == CH_CR) begin
                        res.event_res    = EV_HEADER;
                        res.key_length   = i_state.saved_klen;
                        res.value_length = i_state.field_count;
                        st.field_count   = 16'd0;
                        st.phase         = (i_byte == CH_CR) ? PH_LINE_LF : PH_KEY;
                    end else begin
                        res.event_res = EV_BAD;
                        finish        = 1'b1;
                    end
                end
                PH_LINE_LF: begin
                    if (i_byte == CH_LF) begin
                        st.field_count = 16'd0;
                        st.phase       = PH_KEY;
                    end else begin
                        res.event_res = EV_BAD;
                        finish        = 1'b1;
                    end
                end
                PH_FINAL_LF: begin
                    if (i_byte == CH_LF) begin
                        res.event_res      = EV_DONE;
                        res.consumed_bytes = pos[16:0];
                    end else begin
                        res.event_res = EV_BAD;
                    end
                    finish = 1'b1;
                end
                default: begin
                    res.event_res = EV_BAD;
                    finish        = 1'b1;
                end
            endcase
        end

        // status code reflects the accumulator before any restart
        res.status_code = st.code_acc;
        if (finish) begin
            st = STATE_RESTART;
        end
    end

    assign o_state  = st;
    assign o_result = res;

endmodule

`default_nettype wire

[rtl/http_response_header_parser.sv]
// ----------------------------------------------------------------------------
// http_response_header_parser
// Byte-serial HTTP/1.x response header parser: one event word per input byte.
//
//   channel       dir  handshake    word
//   i_byte_chan   in   valid/ready  in_byte
//   o_event_chan  out  valid/ready  event, data byte, code, lengths, count
//   i_cfg_*       in   write enable key length limit / message byte limit
//
// One byte per cycle unless stalled; each event follows in the next cycle.
// The parser state updates in the cycle the byte is taken and the event word
// sits in an output register, so a new byte is taken whenever that register
// is empty or being drained. Synchronous reset restores the limits to their
// defaults and restarts at the status line. A stall on the result side holds
// the event word and blocks further input only while it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module http_response_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_data,
    hrp_in_if.sink      i_byte_chan,
    hrp_out_if.source   o_event_chan
);
    import hrp_pkg::*;

    logic [4:0]  r_key_limit;
    logic [16:0] r_msg_limit;
    t_state      r_state;
    t_state      n_state;
    t_result     r_result;
    t_result     n_result;
    logic        r_out_valid;
    logic        in_accept;

    // Take a byte when the output register is free or draining
    assign i_byte_chan.ready = !r_out_valid || o_event_chan.ready;
    assign in_accept         = i_byte_chan.valid && i_byte_chan.ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_limit <= KEY_LIMIT_RESET;
            r_msg_limit <= MSG_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_LIMIT: r_key_limit <= i_cfg_data[4:0];
                CFG_MSG_LIMIT: r_msg_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hrp_step u_step (
        .i_state     (r_state),
        .i_byte      (i_byte_chan.in_byte),
        .i_key_limit (r_key_limit),
        .i_msg_limit (r_msg_limit),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // Advance parser state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESTART;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_event_chan.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the event word until taken
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_event_chan.valid          = r_out_valid;
    assign o_event_chan.event_res      = r_result.event_res;
    assign o_event_chan.data_byte      = r_result.data_byte;
    assign o_event_chan.status_code    = r_result.status_code;
    assign o_event_chan.key_length     = r_result.key_length;
    assign o_event_chan.value_length   = r_result.value_length;
    assign o_event_chan.consumed_bytes = r_result.consumed_bytes;

endmodule

`default_nettype wire

[rtl/hrp_checker.sv]
// ----------------------------------------------------------------------------
// hrp_checker
// Port-level checks on the header parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_event_res,
    input logic [7:0]  i_data_byte,
    input logic [16:0] i_consumed_bytes
);
    import hrp_pkg::*;

    // Stalled event word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_event_res) &&
            $stable(i_data_byte) && $stable(i_consumed_bytes))
        else $error("event word changed while stalled");

    // Every accepted byte shows an event in the next cycle
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted byte produced no event");

    // Data byte only with key and value byte events
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_res != EV_KEY_BYTE &&
        i_event_res != EV_VALUE_BYTE |-> i_data_byte == 8'd0)
        else $error("data byte set on non-byte event");

    // Byte count present exactly with message done
    a_count_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            ((i_event_res == EV_DONE) == (i_consumed_bytes != 17'd0)))
        else $error("consumed byte count mismatch with message done");

endmodule

bind http_response_header_parser hrp_checker u_hrp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_byte_chan.valid),
    .i_in_ready       (i_byte_chan.ready),
    .i_out_valid      (o_event_chan.valid),
    .i_out_ready      (o_event_chan.ready),
    .i_event_res      (o_event_chan.event_res),
    .i_data_byte      (o_event_chan.data_byte),
    .i_consumed_bytes (o_event_chan.consumed_bytes)
);

`default_nettype wire

[test/http_response_header_parser_tb.sv]
// ----------------------------------------------------------------------------
// http_response_header_parser_tb
// Drives byte streams of HTTP/1.x responses into the parser through the byte
// channel and checks every event word against an in-bench parser model.
// Covers the status line, header lines, malformed and overlong messages under
// several key and message limits, with random gaps and result-side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module http_response_header_parser_tb;

    import hrp_pkg::*;

    localparam int LIMIT_CYCLES = 200_000;

    // "HTTP/1" packed first character highest
    localparam logic [47:0] VERSION_TEXT = {CH_H, CH_T, CH_T, CH_P, CH_SLASH, CH_ONE};

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_SPARSE_STALL,
        RX_PERIODIC,
        RX_HEAVY_STALL
    } t_rx_mode;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = CFG_KEY_LIMIT;
    logic [16:0] i_cfg_data  = '0;

    logic        drv_valid  = 1'b0;
    logic [7:0]  drv_byte   = '0;
    logic        sink_ready = 1'b0;

    hrp_in_if  byte_ch ();
    hrp_out_if event_ch ();

    assign byte_ch.valid   = drv_valid;
    assign byte_ch.in_byte = drv_byte;
    assign event_ch.ready  = sink_ready;

    http_response_header_parser DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_byte_chan  (byte_ch),
        .o_event_chan (event_ch)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Parser model state and limits
    // ------------------------------------------------------------------------
    t_phase      st_phase;
    logic [16:0] st_count;
    logic [15:0] st_field;
    logic        st_prefix_ok;
    logic [15:0] st_code;
    logic [4:0]  st_klen;

    logic [4:0]  cfg_key_limit = KEY_LIMIT_RESET;
    logic [16:0] cfg_msg_limit = MSG_LIMIT_RESET;

    logic [7:0]  pending_bytes[$];
    t_result     expected_events[$];

    int error_count   = 0;
    int words_checked = 0;
    int bytes_queued  = 0;
    int cycle_count   = 0;

    function automatic void restart_parser();
        st_phase     = PH_PREFIX;
        st_count     = '0;
        st_field     = '0;
        st_prefix_ok = 1'b1;
        st_code      = '0;
        st_klen      = '0;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic is_name_char(input logic [7:0] b);
        return (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z) ||
               (b >= CH_ZERO && b <= CH_NINE) || b == CH_DASH || b == CH_UNDER;
    endfunction

    // Advance the model by one byte and return the event word it causes
    function automatic t_result parse_byte(input logic [7:0] b);
        t_result     r;
        logic [17:0] pos;
        logic [19:0] code_next;
        logic        done;
        r    = '0;
        done = 1'b0;
        pos  = {1'b0, st_count} + 18'd1;
        if (pos > {1'b0, cfg_msg_limit}) begin
            r.event_res = EV_LONG;
            done = 1'b1;
        end else begin
            st_count = pos[16:0];
            case (st_phase)
                PH_PREFIX: begin
                    if (b == CH_DOT) begin
                        if (st_field != PREFIX_LEN || !st_prefix_ok) begin
                            r.event_res = EV_BAD;
                            done = 1'b1;
                        end else begin
                            st_field = '0;
                            st_phase = PH_SUBVER;
                        end
                    end else if ((b >= CH_UP_A && b <= CH_UP_Z) || b == CH_SLASH ||
                                 b == CH_ONE) begin
                        // spelling is judged only once the dot arrives
                        if (st_field >= PREFIX_LEN ||
                            b != VERSION_TEXT[8*(5 - st_field[2:0]) +: 8])
                            st_prefix_ok = 1'b0;
                        st_field = sat_inc(st_field);
                    end else begin
                        r.event_res = EV_BAD;
                        done = 1'b1;
                    end
                end
                PH_SUBVER: begin
                    if (b == CH_SPACE) begin
                        st_code  = '0;
                        st_phase = PH_CODE;
                    end else if ((b == CH_ZERO || b == CH_ONE) && st_field == 0) begin
                        st_field = 16'd1;
                    end else begin
                        r.event_res = EV_BAD;
                        done = 1'b1;
                    end
                end
                PH_CODE: begin
                    if (b == CH_SPACE) begin
                        r.event_res = EV_CODE;
                        st_phase = PH_TEXT;
                    end else if (b >= CH_ZERO && b <= CH_NINE) begin
                        code_next = {4'd0, st_code} * 20'd10 + {12'd0, b - CH_ZERO};
                        st_code = (code_next > 20'hFFFF) ? 16'hFFFF : code_next[15:0];
                    end else begin
                        r.event_res = EV_BAD;
                        done = 1'b1;
                    end
                end
                PH_TEXT: begin
                    if (b == CH_LF) begin
                        st_field = '0;
                        st_phase = PH_KEY;
                    end else if (b == CH_CR) begin
                        st_phase = PH_LINE_LF;
                    end
                end
                PH_KEY: begin
                    if (b == CH_COLON) begin
                        st_klen      = st_field[4:0];
                        r.event_res  = EV_KEY_END;
                        r.key_length = st_klen;
                        st_phase     = PH_SPACES;
                    end else if (st_field == 0 && b == CH_LF) begin
                        r.event_res      = EV_DONE;
                        r.consumed_bytes = pos[16:0];
                        done = 1'b1;
                    end else if (st_field == 0 && b == CH_CR) begin
                        st_phase = PH_FINAL_LF;
                    end else if (st_field >= cfg_key_limit || !is_name_char(b)) begin
                        r.event_res = EV_BAD;
                        done = 1'b1;
                    end else begin
                        r.event_res = EV_KEY_BYTE;
                        r.data_byte = b;
                        st_field    = sat_inc(st_field);
                    end
                end
                PH_SPACES: begin
                    // first non-space byte is taken whatever it is
                    if (b != CH_SPACE) begin
                        r.event_res = EV_VALUE_BYTE;
                        r.data_byte = b;
                        st_field    = 16'd1;
                        st_phase    = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (b >= CH_SPACE) begin
                        r.event_res = EV_VALUE_BYTE;
                        r.data_byte = b;
                        st_field    = sat_inc(st_field);
                    end else if (b == CH_LF || b == CH_CR) begin
                        r.event_res    = EV_HEADER;
                        r.key_length   = st_klen;
                        r.value_length = st_field;
                        st_field       = '0;
                        st_phase       = (b == CH_CR) ? PH_LINE_LF : PH_KEY;
                    end else begin
                        r.event_res = EV_BAD;
                        done = 1'b1;
                    end
                end
                PH_LINE_LF: begin
                    if (b == CH_LF) begin
                        st_field = '0;
                        st_phase = PH_KEY;
                    end else begin
                        r.event_res = EV_BAD;
                        done = 1'b1;
                    end
                end
                PH_FINAL_LF: begin
                    if (b == CH_LF) begin
                        r.event_res      = EV_DONE;
                        r.consumed_bytes = pos[16:0];
                    end else begin
                        r.event_res = EV_BAD;
                    end
                    done = 1'b1;
                end
                default: begin
                    r.event_res = EV_BAD;
                    done = 1'b1;
                end
            endcase
        end
        r.status_code = st_code;
        if (done)
            restart_parser();
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Byte driver: bursts of random length with random gaps
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid  <= 1'b0;
            drv_byte   <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            // predict the event for the word taken at this edge
            if (drv_valid && byte_ch.ready)
                expected_events.push_back(parse_byte(drv_byte));
            if (!drv_valid || byte_ch.ready) begin
                if (gap_left != 0) begin
                    drv_valid <= 1'b0;
                    gap_left  <= gap_left - 1;
                end else if (pending_bytes.size() != 0) begin
                    drv_valid <= 1'b1;
                    drv_byte  <= pending_bytes.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                                   : $urandom_range(1, 8);
                        gap_left   <= $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Event monitor and result-side stall pattern
    // ------------------------------------------------------------------------
    task automatic report_error(input string msg);
        error_count++;
        $display("%s", msg);
    endtask

    task automatic check_event();
        t_result want;
        if (expected_events.size() == 0) begin
            report_error($sformatf("word %0d: event %0d arrived with nothing pending",
                                   words_checked, event_ch.event_res));
            return;
        end
        want = expected_events.pop_front();
        if (event_ch.event_res !== want.event_res)
            report_error($sformatf("word %0d: event %0d, expected %0d",
                                   words_checked, event_ch.event_res, want.event_res));
        if (event_ch.data_byte !== want.data_byte)
            report_error($sformatf("word %0d: data_byte %0d, expected %0d",
                                   words_checked, event_ch.data_byte, want.data_byte));
        if (event_ch.status_code !== want.status_code)
            report_error($sformatf("word %0d: status_code %0d, expected %0d",
                                   words_checked, event_ch.status_code, want.status_code));
        if (event_ch.key_length !== want.key_length)
            report_error($sformatf("word %0d: key_length %0d, expected %0d",
                                   words_checked, event_ch.key_length, want.key_length));
        if (event_ch.value_length !== want.value_length)
            report_error($sformatf("word %0d: value_length %0d, expected %0d",
                                   words_checked, event_ch.value_length, want.value_length));
        if (event_ch.consumed_bytes !== want.consumed_bytes)
            report_error($sformatf("word %0d: consumed_bytes %0d, expected %0d",
                                   words_checked, event_ch.consumed_bytes,
                                   want.consumed_bytes));
        words_checked++;
    endtask

    t_rx_mode rx_mode   = RX_STEADY;
    int       mode_left = 0;
    int       rx_tick   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
            mode_left  <= 0;
        end else begin
            if (sink_ready && event_ch.valid)
                check_event();
            // switch to a random stall behavior when the mode counter runs out
            if (mode_left == 0) begin
                rx_mode   <= t_rx_mode'($urandom_range(0, 3));
                mode_left <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_STEADY:       sink_ready <= 1'b1;
                RX_SPARSE_STALL: sink_ready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC:     sink_ready <= ((rx_tick % 7) < 3);
                default:         sink_ready <= ($urandom_range(0, 3) == 0);
            endcase
            rx_tick <= rx_tick + 1;
        end
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_crlf();
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // End a line with either CR LF or a bare LF
    task automatic send_eol();
        if ($urandom_range(0, 1) != 0)
            send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    function automatic logic [7:0] rand_key_char();
        int r;
        r = $urandom_range(0, 63);
        if (r < 26)
            return 8'(CH_LO_A + r);
        else if (r < 52)
            return 8'(CH_UP_A + (r - 26));
        else if (r < 62)
            return 8'(CH_ZERO + (r - 52));
        else if (r == 62)
            return CH_DASH;
        else
            return CH_UNDER;
    endfunction

    // Hold until every queued byte is taken and every event has come back
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_bytes.size() != 0 || drv_valid || expected_events.size() != 0);
    endtask

    task automatic set_limits(input logic [4:0] key_lim, input logic [16:0] msg_lim);
        wait_idle();
        // let the result register drain before touching the limits
        repeat (3) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_KEY_LIMIT;
        i_cfg_data  <= {12'd0, key_lim};
        @(posedge i_clk);
        i_cfg_index <= CFG_MSG_LIMIT;
        i_cfg_data  <= msg_lim;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_key_limit = key_lim;
        cfg_msg_limit = msg_lim;
    endtask

    // Queue one random response, keys at times too long, optionally damaged
    task automatic send_random_response(input bit damage);
        int start;
        int at;
        int klen;
        int vlen;
        start = pending_bytes.size();
        send_text("HTTP/1.");
        case ($urandom_range(0, 2))
            0:       send_byte(CH_ZERO);
            1:       send_byte(CH_ONE);
            default: ;
        endcase
        send_byte(CH_SPACE);
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3))
            send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        send_byte(CH_SPACE);
        repeat ($urandom_range(0, 6))
            send_byte(8'($urandom_range(32, 255)));
        send_eol();
        repeat ($urandom_range(0, 3)) begin
            klen = ($urandom_range(0, 7) == 0) ? cfg_key_limit + 1
                                               : $urandom_range(0, cfg_key_limit);
            repeat (klen)
                send_byte(rand_key_char());
            send_byte(CH_COLON);
            repeat ($urandom_range(0, 2))
                send_byte(CH_SPACE);
            vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
            send_byte(8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(33, 255)));
            repeat (vlen - 1)
                send_byte(8'($urandom_range(32, 255)));
            send_eol();
        end
        send_eol();
        if (damage) begin
            at = start + $urandom_range(0, pending_bytes.size() - start - 1);
            if ($urandom_range(0, 1) != 0)
                pending_bytes[at] = 8'($urandom_range(0, 255));
            else
                while (pending_bytes.size() > at + 1)
                    void'(pending_bytes.pop_back());
        end
    endtask

    // Mostly clean responses, some damaged ones and some raw noise
    task automatic run_random_traffic(input int target);
        int start;
        int pick;
        start = bytes_queued;
        while (bytes_queued - start < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_random_response(1'b0);
            else if (pick < 88)
                send_random_response(1'b1);
            else
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 19) == 0)
                wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        restart_parser();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Clean messages: CR LF lines, bare LF lines, no subversion, empty code
        send_text("HTTP/1.1 200 OK");
        send_crlf();
        send_text("Content-Length: 5");
        send_crlf();
        send_crlf();
        send_text("HTTP/1.  \n\n");
        // saturated code, empty key, control bytes taken as first value byte
        send_text("HTTP/1.0 99999 x\n: ");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("K:");
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_text("\n\n");
        // key at full length, then one byte past it
        send_text("HTTP/1.1 65535 \nabcdefghijklmnopqrstuvwxyz01234:v\n\n");
        send_text("HTTP/1.1 65536 \nabcdefghijklmnopqrstuvwxyz012345");
        // control byte later in a value
        send_text("HTTP/1.1 200 \nK: a");
        send_byte(8'h1F);
        // bad prefix characters and spellings
        send_text("HTx");
        send_text(".");
        send_text("HTTQ/1.");
        send_text("HTTP/11.");
        send_byte(8'h00);
        // bad subversion and status code
        send_text("HTTP/1.2");
        send_text("HTTP/1.11");
        send_text("HTTP/1.1 2a");
        // bad key bytes
        send_text("HTTP/1.1 200 OK\nA ");
        send_text("HTTP/1.1 200 OK\nAb");
        send_byte(CH_CR);
        // CR not followed by LF in status text, value and blank line
        send_text("HTTP/1.1 200 OK");
        send_byte(CH_CR);
        send_text("X");
        send_text("HTTP/1.1 200 OK\nK: v");
        send_byte(CH_CR);
        send_text("X");
        send_text("HTTP/1.1 200 OK\n");
        send_byte(CH_CR);
        send_text("X");

        // Short key limit and a message one byte over its limit
        set_limits(5'd4, 17'd40);
        send_text("HTTP/1.1 200 \nabcd:x\nabcde");
        send_text("HTTP/1.1 200 OK\nabcd: 012345678901234567Z");
        // Zero key limit: only an empty key passes
        set_limits(5'd0, 17'd100);
        send_text("HTTP/1.1 200 \n:x\nk");
        // Zero and one-byte message limits
        set_limits(5'd5, 17'd0);
        send_text("HT");
        set_limits(5'd5, 17'd1);
        send_text("HTTP");
        // A message of exactly the limit, then one that is a byte longer
        set_limits(5'd31, 17'd20);
        send_text("HTTP/1.1 200 \nK: a\n\n");
        send_text("HTTP/1.1 200 \nK: ab\n\n");

        // Random traffic under several limit settings
        set_limits(KEY_LIMIT_RESET, MSG_LIMIT_RESET);
        run_random_traffic(25);
        set_limits(5'd1, 17'd60);
        run_random_traffic(15);
        set_limits(5'($urandom_range(2, 30)), 17'($urandom_range(20, 400)));
        run_random_traffic(15);
        set_limits(5'd7, 17'd1);
        run_random_traffic(10);

        wait_idle();
        repeat (5) @(posedge i_clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
